// ----- hw/rtl/irins_pkg.sv -----
// Shared constants and command codes for the incremental reachability insert unit.
`default_nettype none

package irins_pkg;

  // Store geometry.
  localparam int MAX_NODES   = 16;
  localparam int NUM_COLOURS = 4;
  localparam int ROW_W       = MAX_NODES;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int COLOUR_W    = $clog2(NUM_COLOURS);
  localparam int ADDR_W      = COLOUR_W + NODE_W;
  localparam int DEPTH       = NUM_COLOURS * MAX_NODES;

  // Row counter that can also hold the node count itself.
  localparam int CNT_W       = $clog2(MAX_NODES + 1);

  // Fixed field widths.
  localparam int CMD_W       = 2;
  localparam int NODE_CNT_W  = 5;

  // Node count register: reset value and lower clamp bound.
  localparam int NODE_CNT_RESET = 16;
  localparam int NODE_CNT_MIN   = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/incremental_reach_insert_unit.sv -----
// Top level of the incremental reachability insert unit: control, row store and checks.
//
//   Channel  Direction  Handshake              Beat contents
//   -------  ---------  ---------------------  ---------------------------------
//   in       input      in_valid / in_stall    cmd, src_node, dst_node, colour
//   out      output     out_valid / out_stall  accepted, reachable
//   cfg      input      cfg_we                 cfg_wdata (node_count)
//
// A committed insert reads the destination row, then makes a check pass and a commit pass
// over the n effective nodes, each limited by the single read port of the row RAM, then
// loads the result and returns to idle. An insert rejected by the check pass skips the
// commit pass. A query reads its row before it loads the result; a clear, a rejected
// command or an unused command loads its result straight from idle. The result shows in
// the same cycle that the unit is back in idle and can take the next beat.
// Reset brings the store back to the identity at once, because
// each row carries a valid bit and a row that is not valid reads as its own node
// bit. A clear command does the same by dropping every valid bit together.
// A new beat is taken while an earlier result still waits at the output; the
// unit only holds in its response state while the output register is full and
// stalled.
`default_nettype none

module incremental_reach_insert_unit (
  input  wire                                clk,
  input  wire                                rst,
  // Configuration.
  input  wire                                cfg_we,
  input  wire  [irins_pkg::NODE_CNT_W-1:0]   cfg_wdata,
  // Input channel.
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [irins_pkg::CMD_W-1:0]        cmd,
  input  wire  [irins_pkg::NODE_W-1:0]       src_node,
  input  wire  [irins_pkg::NODE_W-1:0]       dst_node,
  input  wire  [irins_pkg::COLOUR_W-1:0]     colour,
  // Output channel.
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               accepted,
  output logic                               reachable
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_QWAIT  = 6'b000010,
    S_SUCC   = 6'b000100,
    S_CHECK  = 6'b001000,
    S_COMMIT = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state;

  // Configuration register.
  logic [irins_pkg::NODE_CNT_W-1:0] node_count;

  // Latched command fields.
  logic [irins_pkg::NODE_W-1:0]   src_q;
  logic [irins_pkg::NODE_W-1:0]   dst_q;
  logic [irins_pkg::COLOUR_W-1:0] colour_q;

  // Destination row captured before the passes start.
  logic [irins_pkg::ROW_W-1:0] succ;

  // Row sweep: issue counter, and the row whose data is on the RAM output.
  logic [irins_pkg::CNT_W-1:0]  rd_idx;
  logic                         rd_pend;
  logic [irins_pkg::NODE_W-1:0] rd_row;
  logic                         viol;

  // One valid bit per stored row; an invalid row reads as the identity row.
  logic [irins_pkg::DEPTH-1:0]  row_valid;
  logic                         rd_entry_valid;
  logic [irins_pkg::NODE_W-1:0] rd_ident;

  // Pending response.
  logic resp_acc;
  logic resp_rch;

  // RAM ports.
  logic                         ram_we;
  logic [irins_pkg::ADDR_W-1:0] ram_waddr;
  logic [irins_pkg::ADDR_W-1:0] ram_raddr;
  logic [irins_pkg::ROW_W-1:0]  ram_rdata;

  // Datapath.
  logic [irins_pkg::CNT_W-1:0]  n_eff;
  logic [irins_pkg::CNT_W-1:0]  n_last;
  logic                         in_ok;
  logic [irins_pkg::ROW_W-1:0]  row_data;
  logic [irins_pkg::ROW_W-1:0]  row_next;
  logic [irins_pkg::NODE_W-1:0] pred;
  logic                         row_viol;
  logic                         row_last;
  logic                         issue;
  logic                         in_take;
  logic                         out_load;

  // Node count below the minimum acts as the minimum; above the store size it
  // acts as the store size.
  always_comb begin
    if (node_count < irins_pkg::NODE_CNT_W'(irins_pkg::NODE_CNT_MIN)) begin
      n_eff = irins_pkg::CNT_W'(irins_pkg::NODE_CNT_MIN);
    end else if (irins_pkg::CNT_W'(node_count) > irins_pkg::CNT_W'(irins_pkg::MAX_NODES)) begin
      n_eff = irins_pkg::CNT_W'(irins_pkg::MAX_NODES);
    end else begin
      n_eff = irins_pkg::CNT_W'(node_count);
    end
  end

  assign n_last = n_eff - 1'b1;

  assign in_ok = (irins_pkg::CNT_W'(src_node) < n_eff) &&
                 (irins_pkg::CNT_W'(dst_node) < n_eff) &&
                 (int'(colour) < irins_pkg::NUM_COLOURS);

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Row as seen by the logic: RAM data if the row was ever written since the
  // last clear or reset, otherwise the identity row.
  assign row_data = rd_entry_valid ? ram_rdata : (irins_pkg::ROW_W'(1) << rd_ident);

  // Every row that reaches the source also reaches all that the destination reaches.
  assign row_next = row_data[src_q] ? (row_data | succ) : row_data;

  // Cyclic predecessor of the row under test.
  assign pred     = (rd_row == '0) ? n_last[irins_pkg::NODE_W-1:0] : rd_row - 1'b1;
  assign row_viol = row_next[pred];
  assign row_last = (irins_pkg::CNT_W'(rd_row) == n_last);

  assign issue = ((state == S_CHECK) || (state == S_COMMIT)) && (rd_idx < n_eff);

  // In idle the read address comes straight from the beat so that the first
  // row is ready in the next cycle.
  always_comb begin
    if (state == S_IDLE) begin
      ram_raddr = {colour, (cmd == irins_pkg::CMD_QUERY) ? src_node : dst_node};
    end else begin
      ram_raddr = {colour_q, rd_idx[irins_pkg::NODE_W-1:0]};
    end
  end

  // The commit pass writes each row in the cycle after its read; the next read is
  // always to a different row, so no forwarding is needed.
  assign ram_we    = (state == S_COMMIT) && rd_pend;
  assign ram_waddr = {colour_q, rd_row};

  assign out_load = (state == S_RESP) && (!out_valid || !out_stall);

  irins_ram #(
    .WIDTH (irins_pkg::ROW_W),
    .DEPTH (irins_pkg::DEPTH)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (row_next),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    rd_entry_valid <= row_valid[ram_raddr];
    rd_ident       <= ram_raddr[irins_pkg::NODE_W-1:0];
    if (issue) begin
      rd_row <= rd_idx[irins_pkg::NODE_W-1:0];
    end
    if (in_take) begin
      src_q    <= src_node;
      dst_q    <= dst_node;
      colour_q <= colour;
    end
    if (state == S_SUCC) begin
      succ <= row_data;
    end
    if (out_load) begin
      accepted  <= resp_acc;
      reachable <= resp_rch;
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= irins_pkg::NODE_CNT_W'(irins_pkg::NODE_CNT_RESET);
      row_valid  <= '0;
      rd_pend    <= 1'b0;
      rd_idx     <= '0;
      viol       <= 1'b0;
      resp_acc   <= 1'b0;
      resp_rch   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end

      rd_pend <= issue;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end

      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            resp_acc <= 1'b0;
            resp_rch <= 1'b0;
            state    <= S_RESP;
            case (cmd)
              irins_pkg::CMD_CLEAR: begin
                row_valid <= '0;
                resp_acc  <= 1'b1;
              end
              irins_pkg::CMD_QUERY: begin
                if (in_ok) begin
                  state <= S_QWAIT;
                end
              end
              irins_pkg::CMD_INSERT: begin
                if (in_ok) begin
                  state <= S_SUCC;
                end
              end
              default: begin
                resp_acc <= 1'b0;
              end
            endcase
          end
        end
        S_QWAIT: begin
          resp_acc <= 1'b1;
          resp_rch <= row_data[dst_q];
          state    <= S_RESP;
        end
        S_SUCC: begin
          rd_idx <= '0;
          viol   <= 1'b0;
          state  <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_pend) begin
            viol <= viol | row_viol;
            if (row_last) begin
              if (viol || row_viol) begin
                resp_acc <= 1'b0;
                state    <= S_RESP;
              end else begin
                rd_idx <= '0;
                state  <= S_COMMIT;
              end
            end
          end
        end
        S_COMMIT: begin
          if (rd_pend && row_last) begin
            resp_acc <= 1'b1;
            state    <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The row store is only written during the commit pass.
  a_write_in_commit: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_COMMIT))
    else $error("row write outside the commit pass");

  // A commit never touches a row at or above the node count.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (irins_pkg::CNT_W'(rd_row) < n_eff))
    else $error("row write beyond the node count");

  // A clear drops every row back to the identity by dropping all valid bits together.
  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (in_take && (cmd == irins_pkg::CMD_CLEAR)) |=> (row_valid == '0))
    else $error("clear left valid rows behind");

  // A new result is only loaded from the response state.
  a_load_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESP))
    else $error("result loaded outside the response state");

  // The sweep never has a read in flight outside the two passes and the response state.
  a_pend_in_pass: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ((state == S_CHECK) || (state == S_COMMIT) || (state == S_RESP)))
    else $error("row read in flight outside a pass");

endmodule

`default_nettype wire

// ----- hw/rtl/irins_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module irins_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- tb/sv/irins_checker.sv -----
// Checker for the reachability insert unit: watches both channels, predicts each result and compares.
`default_nettype none

module irins_reach_checker
  import irins_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire  [NODE_CNT_W-1:0] cfg_wdata,
  input  wire                   in_valid,
  input  wire                   in_stall,
  input  wire  [CMD_W-1:0]      cmd,
  input  wire  [NODE_W-1:0]     src_node,
  input  wire  [NODE_W-1:0]     dst_node,
  input  wire  [COLOUR_W-1:0]   colour,
  input  wire                   out_valid,
  input  wire                   out_stall,
  input  wire                   accepted,
  input  wire                   reachable,
  output int                    mismatch_count,
  output int                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic accepted;
    logic reachable;
  } reach_reply_t;

  logic [ROW_W-1:0]      reach_map [NUM_COLOURS][MAX_NODES];
  logic [NODE_CNT_W-1:0] node_cnt;
  reach_reply_t          reply_q [$];
  int                    reply_seen;

  task automatic report_mismatch(input string what);
    $display("%0t ns: result %0d: %s", $time, reply_seen, what);
    mismatch_count++;
  endtask

  // Appends one predicted result at the tail of the queue.
  task automatic enqueue_reply(input reach_reply_t r);
    reply_q.insert(reply_q.size(), r);
  endtask

  function automatic void load_identity();
    for (int c = 0; c < NUM_COLOURS; c++)
      for (int x = 0; x < MAX_NODES; x++)
        reach_map[c][x] = ROW_W'(1) << x;
  endfunction

  function automatic int active_nodes();
    if (node_cnt < NODE_CNT_MIN) return NODE_CNT_MIN;
    if (node_cnt > MAX_NODES) return MAX_NODES;
    return node_cnt;
  endfunction

  // Every row holding the source bit picks up the destination's old row. The first n
  // rows of the colour are then audited: no row may reach its cyclic predecessor.
  function automatic logic apply_insert(input int s, input int d, input int c, input int n);
    logic [ROW_W-1:0] staged [MAX_NODES];
    logic [ROW_W-1:0] dst_row;
    int               pred;
    dst_row = reach_map[c][d];
    for (int x = 0; x < n; x++) begin
      staged[x] = reach_map[c][x];
      if (staged[x][s]) staged[x] = staged[x] | dst_row;
    end
    for (int x = 0; x < n; x++) begin
      pred = (x + n - 1) % n;
      if (staged[x][pred]) return 1'b0;
    end
    for (int x = 0; x < n; x++) reach_map[c][x] = staged[x];
    return 1'b1;
  endfunction

  function automatic reach_reply_t resolve_command(input logic [CMD_W-1:0] op, input int s,
                                                   input int d, input int c);
    reach_reply_t r;
    int           n;
    logic         in_range;
    n        = active_nodes();
    in_range = (s < n) && (d < n) && (c < NUM_COLOURS);
    r        = '0;
    case (op)
      CMD_INSERT: r.accepted = in_range && apply_insert(s, d, c, n);
      CMD_QUERY: begin
        r.accepted  = in_range;
        r.reachable = in_range && reach_map[c][s][d];
      end
      CMD_CLEAR: begin
        load_identity();
        r.accepted = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reach_reply_t want;
    if (rst) begin
      node_cnt = NODE_CNT_W'(NODE_CNT_RESET);
      load_identity();
      reply_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result beat with no command outstanding");
        end else begin
          want = reply_q.pop_front();
          if (accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, predicted %b", accepted, want.accepted));
          if (reachable !== want.reachable)
            report_mismatch($sformatf("reachable %b, predicted %b", reachable, want.reachable));
        end
        reply_seen++;
      end
      if (in_valid && !in_stall)
        enqueue_reply(resolve_command(cmd, src_node, dst_node, colour));
      if (cfg_we) node_cnt = cfg_wdata;
    end
    pending_results = reply_q.size();
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench top for the reachability insert unit: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
  import irins_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The unused fourth command code; the unit must answer it with a plain reject.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // Slowest honest run is roughly 450 beats plus stalls and gaps, so this limit
  // leaves a wide margin.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BEATS = 72;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [NODE_CNT_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic [CMD_W-1:0]      cmd       = '0;
  logic [NODE_W-1:0]     src_node  = '0;
  logic [NODE_W-1:0]     dst_node  = '0;
  logic [COLOUR_W-1:0]   colour    = '0;
  logic                  out_stall = 1'b0;
  wire                   in_stall;
  wire                   out_valid;
  wire                   accepted;
  wire                   reachable;

  // While steady is set neither side inserts idle cycles, which gives one long
  // stretch of back-to-back traffic.
  logic steady = 1'b0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   pending_results;

  incremental_reach_insert_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .src_node  (src_node),
    .dst_node  (dst_node),
    .colour    (colour),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .accepted  (accepted),
    .reachable (reachable)
  );

  irins_reach_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .src_node        (src_node),
    .dst_node        (dst_node),
    .colour          (colour),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .accepted        (accepted),
    .reachable       (reachable),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Outside the steady phase the receiver stalls on about 27 percent of cycles. The draw
  // is made at every falling edge, so stalls land on every phase of the unit's work.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 27);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[incremental_reach_insert_unit] ERROR");
      $finish;
    end
  end

  // Node count as the unit sees it after clamping the register value.
  function automatic int clamp_nodes(input int v);
    if (v < NODE_CNT_MIN) return NODE_CNT_MIN;
    if (v > MAX_NODES) return MAX_NODES;
    return v;
  endfunction

  // Drives one beat and returns just after the rising edge that took it. Inputs only
  // change at falling edges, and each falling edge sees one assignment to in_valid,
  // so a valid that stays high for back-to-back beats is never dropped in between.
  task automatic send_beat(input logic [CMD_W-1:0] op, input int s, input int d, input int c);
    while (!steady && $urandom_range(99) < 27) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= op;
    src_node <= NODE_W'(s);
    dst_node <= NODE_W'(d);
    colour   <= COLOUR_W'(c);
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending and waits until every outstanding result has come back. Every
  // command yields exactly one result, so the unit is idle at that point.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_node_count(input int v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= NODE_CNT_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random beat for a store with n active nodes. Most beats are inserts, chiefly
  // of forward edges (lower node to higher node), which mostly commit and so grow the
  // closure; the rest are queries, clears, the spare code and node indexes beyond
  // the active count. Color 0 is favored so that its matrix fills up deeply.
  task automatic random_beat(input int n);
    int               roll;
    int               a;
    int               b;
    int               c;
    int               t;
    logic [CMD_W-1:0] op;
    roll = $urandom_range(99);
    c    = $urandom_range(1) ? 0 : $urandom_range(NUM_COLOURS - 1);
    a    = $urandom_range(n - 1);
    b    = $urandom_range(n - 1);
    if (roll < 55) begin
      op = CMD_INSERT;
      if ($urandom_range(9) < 7 && a > b) begin
        t = a;
        a = b;
        b = t;
      end
    end else if (roll < 84) begin
      op = CMD_QUERY;
    end else if (roll < 88) begin
      op = CMD_CLEAR;
      a  = $urandom_range(MAX_NODES - 1);
      b  = $urandom_range(MAX_NODES - 1);
    end else if (roll < 92) begin
      op = CMD_SPARE;
      a  = $urandom_range(MAX_NODES - 1);
      b  = $urandom_range(MAX_NODES - 1);
    end else begin
      op = $urandom_range(1) ? CMD_INSERT : CMD_QUERY;
      if (n < MAX_NODES) b = $urandom_range(MAX_NODES - 1, n);
      if ($urandom_range(1)) begin
        t = a;
        a = b;
        b = t;
      end
    end
    send_beat(op, a, b, c);
  endtask

  initial begin
    int cfg_values [6];
    int n;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at sixteen nodes, starting from the identity store.
    write_node_count(16);
    send_beat(CMD_QUERY, 0, 0, 0);              // a node reaches itself
    send_beat(CMD_QUERY, 15, 15, 3);            // highest node, highest color
    send_beat(CMD_QUERY, 0, 15, 3);             // not reachable yet
    send_beat(CMD_INSERT, 0, 15, 0);            // 0 would reach 15, its wrapped predecessor
    send_beat(CMD_INSERT, 0, 1, 0);             // plain forward edge commits
    send_beat(CMD_INSERT, 1, 0, 0);             // 1 would reach its predecessor 0
    send_beat(CMD_INSERT, 1, 2, 0);             // row 0 also picks up node 2
    send_beat(CMD_QUERY, 0, 2, 0);              // transitive bit is set
    send_beat(CMD_QUERY, 0, 2, 1);              // other colors stay untouched
    send_beat(CMD_INSERT, 15, 14, 1);           // 15 would reach its predecessor 14
    send_beat(CMD_INSERT, 14, 15, 3);           // forward edge at the top of the range
    send_beat(CMD_SPARE, 15, 15, 3);            // unused command code
    send_beat(CMD_INSERT, 2, 3, 0);

    // Shrinking the node count to three leaves row 0 of color 0 holding node 2, which
    // is now its predecessor: the old violation has to reject every insert there.
    drain_results();
    write_node_count(3);
    send_beat(CMD_INSERT, 1, 1, 0);             // rejected by the leftover violation
    send_beat(CMD_INSERT, 0, 1, 2);             // a clean color still commits
    send_beat(CMD_QUERY, 3, 0, 0);              // source beyond the node count
    send_beat(CMD_INSERT, 0, 3, 1);             // destination beyond the node count
    send_beat(CMD_QUERY, 15, 15, 2);
    send_beat(CMD_QUERY, 0, 2, 0);              // the stale bit is still readable
    send_beat(CMD_CLEAR, 0, 0, 0);
    send_beat(CMD_QUERY, 0, 2, 0);              // gone after the clear
    send_beat(CMD_INSERT, 0, 1, 0);             // and color 0 accepts inserts again

    // Random phases, one register value each. 31 and 17 clamp to sixteen nodes and
    // 0 clamps to three; between them every register bit takes both values.
    cfg_values = '{16, 31, 0, 3, $urandom_range(15, 4), 17};
    foreach (cfg_values[p]) begin
      drain_results();
      write_node_count(cfg_values[p]);
      n      = clamp_nodes(cfg_values[p]);
      steady = (p == 1);
      if ($urandom_range(1)) send_beat(CMD_CLEAR, 0, 0, 0);
      repeat (PHASE_BEATS) random_beat(n);
    end
    steady = 1'b0;

    // Let the last results drain, then give the unit a little time to show any
    // stray beat before the verdict.
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("[incremental_reach_insert_unit] OK");
    end else begin
      $display("[incremental_reach_insert_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
